// File: design/tkrh_pkg.sv
// Package for the top-K rate heap: sizes, heap entry type, commands and
// sequencer states. No dependencies.
package tkrh_pkg;

    localparam int HEAP_SIZE = 10;
    localparam int POS_W     = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
    localparam int CNT_W     = $clog2(HEAP_SIZE + 1);
    localparam int CHILD_W   = POS_W + 2;
    localparam int KEY_W     = 32;
    localparam int RATE_W    = 32;
    localparam int IDX_W     = 6;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SK_LEFT,
        ST_SK_RIGHT,
        ST_SK_PICK,
        ST_RS_PARENT,
        ST_RS_CMP,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// File: design/tkrh_store.sv
// Heap slot store: one write port, one registered read port, per-slot valid
// bits so that unwritten slots read as empty. Depends on tkrh_pkg.
module tkrh_store
    import tkrh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t                 mem [HEAP_SIZE];
    logic [HEAP_SIZE-1:0]   valid_reg;
    logic                   rd_valid_reg;
    entry_t                 rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/top_k_rate_heap_unit.sv
// Top level of the top-K rate heap: command sequencer around the slot store.
// Depends on tkrh_pkg and tkrh_store.
//
// Keeps the HEAP_SIZE keys with the largest rates in a min-heap ordered by
// rate, smallest at the root. Input channel: item_valid / item_stall with
// command, entry_key, rate_value, slot_index. Output channel: result_valid /
// result_stall with slot_key, slot_rate, evicted_key, evicted_flag,
// key_was_present, entered_flag. Every input transfer yields one result.
// Steps from input transfer to the result:
//   read, offer key 0: straight to the result
//   offer: a full key scan over the HEAP_SIZE slots (shorter when the key sits
//          in an early slot), then the entry moves level by level toward
//          the leaves or toward the root until it stops, then the final
//          write of a moved entry.
// One item is in work at a time; item_stall is high until the sequencer is
// back to idle, so the next transfer can come at the edge the result is
// first offered. While result_stall is high a finished item waits in the
// output register and the next one holds in its last step.
// Reset empties the heap (all keys and rates read as zero) and drops any
// pending result.
module top_k_rate_heap_unit
    import tkrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              command,
    input  logic [KEY_W-1:0]  entry_key,
    input  logic [RATE_W-1:0] rate_value,
    input  logic [IDX_W-1:0]  slot_index,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [KEY_W-1:0]  slot_key,
    output logic [RATE_W-1:0] slot_rate,
    output logic [KEY_W-1:0]  evicted_key,
    output logic              evicted_flag,
    output logic              key_was_present,
    output logic              entered_flag
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              present_reg, present_next;
    logic              entered_reg, entered_next;
    logic              rd_hit_reg, rd_hit_next;
    logic              res_valid_reg, res_valid_next;

    logic              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [KEY_W-1:0]  evict_reg, evict_next;
    entry_t            root_reg, root_next;
    entry_t            child_reg, child_next;
    logic [POS_W-1:0]  child_pos_reg, child_pos_next;

    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [RATE_W-1:0] out_rate_reg, out_rate_next;
    logic [KEY_W-1:0]  out_evict_reg, out_evict_next;
    logic              out_eflag_reg, out_eflag_next;
    logic              out_present_reg, out_present_next;
    logic              out_entered_reg, out_entered_next;

    mem_req_t          req;
    entry_t            rd_data;

    logic [CNT_W-1:0]   cnt_m1;
    logic [POS_W-1:0]   pos_m1;
    logic [POS_W-1:0]   parent_pos;
    logic [CHILD_W-1:0] left_pos;
    logic [CHILD_W-1:0] right_pos;
    logic               have_right;
    entry_t             pick;
    logic [POS_W-1:0]   pick_pos;
    logic               out_free;

    tkrh_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign pos_m1     = pos_reg - POS_W'(1);
    assign parent_pos = pos_m1 >> 1;
    assign left_pos   = {1'b0, pos_reg, 1'b1};
    assign right_pos  = left_pos + CHILD_W'(1);
    assign have_right = right_pos < CHILD_W'(HEAP_SIZE);

    // left child wins ties
    always_comb
    begin
        if (have_right && (child_reg.rate > rd_data.rate))
        begin
            pick     = rd_data;
            pick_pos = right_pos[POS_W-1:0];
        end
        else
        begin
            pick     = child_reg;
            pick_pos = child_pos_reg;
        end
    end

    assign out_free = !res_valid_reg || !result_stall;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        present_next     = present_reg;
        entered_next     = entered_reg;
        rd_hit_next      = rd_hit_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        rate_next        = rate_reg;
        evict_next       = evict_reg;
        root_next        = root_reg;
        child_next       = child_reg;
        child_pos_next   = child_pos_reg;
        out_key_next     = out_key_reg;
        out_rate_next    = out_rate_reg;
        out_evict_next   = out_evict_reg;
        out_eflag_next   = out_eflag_reg;
        out_present_next = out_present_reg;
        out_entered_next = out_entered_reg;
        res_valid_next   = res_valid_reg && result_stall;
        req              = '0;
        item_stall       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next     = command;
                    key_next     = entry_key;
                    rate_next    = rate_value;
                    present_next = 1'b0;
                    entered_next = 1'b0;
                    evict_next   = '0;
                    rd_hit_next  = 1'b0;
                    cnt_next     = '0;
                    if (command == CMD_READ)
                    begin
                        if ({1'b0, slot_index} < (IDX_W + 1)'(HEAP_SIZE))
                        begin
                            rd_hit_next = 1'b1;
                            req.rd_en   = 1'b1;
                            req.rd_addr = slot_index[POS_W-1:0];
                        end
                        state_next = ST_DONE;
                    end
                    else if (entry_key == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // read slot cnt while checking slot cnt-1
            ST_SCAN:
            begin
                if (cnt_reg < CNT_W'(HEAP_SIZE))
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cnt_reg[POS_W-1:0];
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    root_next = rd_data;
                end
                if ((cnt_reg != '0) && (rd_data.key == key_reg))
                begin
                    present_next = 1'b1;
                    pos_next     = cnt_m1[POS_W-1:0];
                    if (rate_reg > rd_data.rate)
                    begin
                        state_next = ST_SK_LEFT;
                    end
                    else if (rate_reg < rd_data.rate)
                    begin
                        state_next = ST_RS_PARENT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (cnt_reg == CNT_W'(HEAP_SIZE))
                begin
                    // new key: displaces the root only when strictly above it
                    if (rate_reg > root_reg.rate)
                    begin
                        evict_next   = root_reg.key;
                        entered_next = 1'b1;
                        pos_next     = '0;
                        state_next   = ST_SK_LEFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_SK_LEFT:
            begin
                if (left_pos < CHILD_W'(HEAP_SIZE))
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = left_pos[POS_W-1:0];
                    state_next  = ST_SK_RIGHT;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_SK_RIGHT:
            begin
                child_next     = rd_data;
                child_pos_next = left_pos[POS_W-1:0];
                if (have_right)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = right_pos[POS_W-1:0];
                end
                state_next = ST_SK_PICK;
            end

            // the moving entry stays in rate_reg; children shift into the hole
            ST_SK_PICK:
            begin
                if (rate_reg > pick.rate)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = pos_reg;
                    req.wr_data = pick;
                    pos_next    = pick_pos;
                    state_next  = ST_SK_LEFT;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_RS_PARENT:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = parent_pos;
                    state_next  = ST_RS_CMP;
                end
            end

            ST_RS_CMP:
            begin
                if (rate_reg < rd_data.rate)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = pos_reg;
                    req.wr_data = rd_data;
                    pos_next    = parent_pos;
                    state_next  = ST_RS_PARENT;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                req.wr_en        = 1'b1;
                req.wr_addr      = pos_reg;
                req.wr_data.key  = key_reg;
                req.wr_data.rate = rate_reg;
                state_next       = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    if ((cmd_reg == CMD_READ) && rd_hit_reg)
                    begin
                        out_key_next  = rd_data.key;
                        out_rate_next = rd_data.rate;
                    end
                    else
                    begin
                        out_key_next  = '0;
                        out_rate_next = '0;
                    end
                    out_evict_next   = evict_reg;
                    out_eflag_next   = entered_reg && (evict_reg != '0);
                    out_present_next = present_reg;
                    out_entered_next = entered_reg;
                    res_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            present_reg   <= 1'b0;
            entered_reg   <= 1'b0;
            rd_hit_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            present_reg   <= present_next;
            entered_reg   <= entered_next;
            rd_hit_reg    <= rd_hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        rate_reg        <= rate_next;
        evict_reg       <= evict_next;
        root_reg        <= root_next;
        child_reg       <= child_next;
        child_pos_reg   <= child_pos_next;
        out_key_reg     <= out_key_next;
        out_rate_reg    <= out_rate_next;
        out_evict_reg   <= out_evict_next;
        out_eflag_reg   <= out_eflag_next;
        out_present_reg <= out_present_next;
        out_entered_reg <= out_entered_next;
    end

    assign result_valid    = res_valid_reg;
    assign slot_key        = out_key_reg;
    assign slot_rate       = out_rate_reg;
    assign evicted_key     = out_evict_reg;
    assign evicted_flag    = out_eflag_reg;
    assign key_was_present = out_present_reg;
    assign entered_flag    = out_entered_reg;

endmodule
